// ===== hw/rtl/first_fit_bump_heap_allocator_core_assert.svh =====
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef FIRST_FIT_BUMP_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BUMP_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFBHA_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFBHA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/ffbha_pkg.sv =====
package ffbha_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_ALIGNED = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;
  localparam logic [1:0] OP_REALLOC = 2'd3;

  // Status codes of a result word.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_PAGES   = 3'd2;
  localparam logic [2:0] ST_TABLE   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_PAGE_LIMIT = 1'b1;

  // Reset value of the page limit.
  localparam logic [15:0] PAGE_LIMIT_RESET = 16'd256;

  // One block table entry.
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        free;
  } entry_t;

  // Control strobes toward the block table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_MARK_OLD,
    S_BUMP,
    S_ALN1,
    S_ALN2,
    S_ALN3,
    S_ALN4,
    S_COVER,
    S_WR_GAP,
    S_WR_BLK,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/ffbha_in_if.sv =====
interface ffbha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] request_bytes;
  logic [31:0] align_bytes;
  logic [31:0] block_address;

  modport source (output valid, op, request_bytes, align_bytes, block_address,
                  input ready);
  modport sink (input valid, op, request_bytes, align_bytes, block_address,
                output ready);
endinterface

// ===== hw/rtl/ffbha_out_if.sv =====
interface ffbha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [2:0]  status;
  logic [31:0] copy_bytes;

  modport source (output valid, result_address, status, copy_bytes, input ready);
  modport sink (input valid, result_address, status, copy_bytes, output ready);
endinterface

// ===== hw/rtl/ffbha_cfg_if.sv =====
interface ffbha_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ffbha_table.sv =====
module ffbha_table
  import ffbha_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  tbl_req_t      req,
  input  logic [IW-1:0] wr_idx,
  input  entry_t        wr_data,
  input  logic [IW-1:0] rd_idx,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ===== hw/rtl/first_fit_bump_heap_allocator_core.sv =====
// A free or reallocate search walks the table entries in order through the
// single read port of the block table; a moving reallocate scans twice.
// One word is taken at a time: a new word is accepted only in the idle state.
// Reset (synchronous, rst_n low) empties the table, bump position and pages.
`include "first_fit_bump_heap_allocator_core_assert.svh"

module first_fit_bump_heap_allocator_core
  import ffbha_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16,
  parameter int PAGE_BYTES   = 4096
) (
  input logic        clk,
  input logic        rst_n,
  ffbha_in_if.sink   in_chan,
  ffbha_out_if.source out_chan,
  ffbha_cfg_if.sink  cfg_chan
);

  // PAGE_BYTES must be a power of two.
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int PS = $clog2(PAGE_BYTES);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
  localparam logic [36:0] HDR37 = 37'(HEADER_BYTES);
  localparam logic [36:0] PAGE_M1 = 37'(PAGE_BYTES - 1);
  localparam logic [CW:0] MAXC = (CW + 1)'(MAX_BLOCKS);

  state_t state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] req_r, req_nxt;
  logic [31:0] align_r, align_nxt;
  logic [31:0] baddr_r, baddr_nxt;
  logic        scan_fit_r, scan_fit_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic        chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  entry_t      hit_ent_r, hit_ent_nxt;
  logic        mark_free_r, mark_free_nxt;
  logic [IW-1:0] k_idx_r, k_idx_nxt;
  entry_t      k_ent_r, k_ent_nxt;
  logic        moving_r, moving_nxt;
  logic [36:0] x_r, x_nxt;
  logic [36:0] pos_r, pos_nxt;
  logic [36:0] end_r, end_nxt;
  logic        gap_r, gap_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] copy_r, copy_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] bump_r, bump_nxt;
  logic [15:0] pages_r, pages_nxt;
  logic [31:0] base_r;
  logic [15:0] limit_r;
  logic        out_vld_r;
  logic [31:0] out_addr_r;
  logic [2:0]  out_st_r;
  logic [31:0] out_copy_r;

  tbl_req_t      tbl_req;
  logic [IW-1:0] tbl_wr_idx;
  entry_t        tbl_wr_data;
  entry_t        rd_ent;

  logic        in_acc;
  logic        out_load;
  logic [31:0] pay_addr;
  logic        match;
  logic        issue;
  logic [36:0] bump37;
  logic [36:0] base37;
  logic [36:0] mask37;
  logic        mis;
  logic [36:0] diff;
  logic        gap;
  logic [CW:0] slots_sum;
  logic [36:0] held_bytes;
  logic [36:0] need;
  logic        fits;
  logic        need_ok;

  ffbha_table #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_table (
    .clk     (clk),
    .req     (tbl_req),
    .wr_idx  (tbl_wr_idx),
    .wr_data (tbl_wr_data),
    .rd_idx  (idx_r[IW-1:0]),
    .rd_data (rd_ent)
  );

  // Handshakes.
  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_load       = (state_r == S_DONE) && (!out_vld_r || out_chan.ready);

  // Scan compare: first fit by size, or lookup by payload address.
  assign pay_addr = base_r + rd_ent.offset + HDR32;
  assign match    = chk_vld_r && (scan_fit_r ? (rd_ent.free && rd_ent.size >= req_r)
                                             : (pay_addr == baddr_r));
  assign issue    = !match && (idx_r < count_r);

  // Alignment arithmetic, signed on 37 bits so no step wraps.
  assign bump37    = {5'b0, bump_r};
  assign base37    = {5'b0, base_r};
  assign mask37    = {5'b0, align_r - 32'd1};
  assign mis       = (x_r & mask37) != 37'd0;
  assign diff      = pos_r - bump37;
  assign gap       = diff[36] || (diff > HDR37);
  assign slots_sum = {1'b0, count_r} + (gap ? (CW + 1)'(2) : (CW + 1)'(1));

  // Page cover check.
  assign held_bytes = 37'(pages_r) << PS;
  assign need       = (end_r + PAGE_M1) >> PS;
  assign fits       = !end_r[36] && (end_r <= held_bytes);
  assign need_ok    = !end_r[36] && (need <= 37'(limit_r));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= 32'd0;
      limit_r <= PAGE_LIMIT_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_HEAP_BASE:  base_r  <= cfg_chan.data;
        CFG_PAGE_LIMIT: limit_r <= cfg_chan.data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      bump_r  <= 32'd0;
      pages_r <= 16'd0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bump_r  <= bump_nxt;
      pages_r <= pages_nxt;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    req_r       <= req_nxt;
    align_r     <= align_nxt;
    baddr_r     <= baddr_nxt;
    scan_fit_r  <= scan_fit_nxt;
    idx_r       <= idx_nxt;
    chk_vld_r   <= chk_vld_nxt;
    chk_idx_r   <= chk_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_ent_r   <= hit_ent_nxt;
    mark_free_r <= mark_free_nxt;
    k_idx_r     <= k_idx_nxt;
    k_ent_r     <= k_ent_nxt;
    moving_r    <= moving_nxt;
    x_r         <= x_nxt;
    pos_r       <= pos_nxt;
    end_r       <= end_nxt;
    gap_r       <= gap_nxt;
    st_r        <= st_nxt;
    addr_r      <= addr_nxt;
    copy_r      <= copy_nxt;
  end

  // Next state and table control.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    align_nxt     = align_r;
    baddr_nxt     = baddr_r;
    scan_fit_nxt  = scan_fit_r;
    idx_nxt       = idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    mark_free_nxt = mark_free_r;
    k_idx_nxt     = k_idx_r;
    k_ent_nxt     = k_ent_r;
    moving_nxt    = moving_r;
    x_nxt         = x_r;
    pos_nxt       = pos_r;
    end_nxt       = end_r;
    gap_nxt       = gap_r;
    st_nxt        = st_r;
    addr_nxt      = addr_r;
    copy_nxt      = copy_r;
    count_nxt     = count_r;
    bump_nxt      = bump_r;
    pages_nxt     = pages_r;
    tbl_req       = '0;
    tbl_wr_idx    = count_r[IW-1:0];
    tbl_wr_data   = hit_ent_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_chan.op;
          req_nxt      = in_chan.request_bytes;
          align_nxt    = in_chan.align_bytes;
          baddr_nxt    = in_chan.block_address;
          st_nxt       = ST_OK;
          addr_nxt     = 32'd0;
          copy_nxt     = 32'd0;
          moving_nxt   = 1'b0;
          idx_nxt      = '0;
          chk_vld_nxt  = 1'b0;
          case (in_chan.op)
            OP_ALIGNED: begin
              if (in_chan.request_bytes == 32'd0 || in_chan.align_bytes == 32'd0) begin
                st_nxt    = ST_ZERO;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_ALN1;
              end
            end
            OP_FREE: begin
              scan_fit_nxt = 1'b0;
              state_nxt    = (in_chan.block_address == 32'd0) ? S_DONE : S_SCAN;
            end
            default: begin
              // Allocate, or reallocate that acts as one.
              if (in_chan.op == OP_REALLOC && in_chan.block_address != 32'd0 &&
                  in_chan.request_bytes != 32'd0) begin
                scan_fit_nxt = 1'b0;
                state_nxt    = S_SCAN;
              end else if (in_chan.request_bytes == 32'd0) begin
                st_nxt    = ST_ZERO;
                state_nxt = S_DONE;
              end else begin
                scan_fit_nxt = 1'b1;
                state_nxt    = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // One entry read per cycle; its data is checked in the next cycle.
        chk_vld_nxt = issue;
        if (issue) begin
          tbl_req.rd_en = 1'b1;
          chk_idx_nxt   = idx_r[IW-1:0];
          idx_nxt       = idx_r + CW'(1);
        end
        if (match) begin
          hit_idx_nxt   = chk_idx_r;
          hit_ent_nxt   = rd_ent;
          mark_free_nxt = !scan_fit_r;
          if (scan_fit_r) begin
            addr_nxt  = pay_addr;
            state_nxt = S_MARK;
          end else if (op_r == OP_FREE) begin
            state_nxt = S_MARK;
          end else if (rd_ent.size >= req_r) begin
            addr_nxt  = baddr_r;
            state_nxt = S_DONE;
          end else begin
            // Block too small: search again for a new one.
            k_idx_nxt    = chk_idx_r;
            k_ent_nxt    = rd_ent;
            moving_nxt   = 1'b1;
            scan_fit_nxt = 1'b1;
            idx_nxt      = '0;
            chk_vld_nxt  = 1'b0;
          end
        end else if (!issue) begin
          if (scan_fit_r) begin
            state_nxt = S_BUMP;
          end else begin
            st_nxt    = ST_UNKNOWN;
            state_nxt = S_DONE;
          end
        end
      end

      S_MARK: begin
        tbl_req.wr_en    = 1'b1;
        tbl_wr_idx       = hit_idx_r;
        tbl_wr_data      = hit_ent_r;
        tbl_wr_data.free = mark_free_r;
        state_nxt        = moving_r ? S_MARK_OLD : S_DONE;
      end

      S_MARK_OLD: begin
        tbl_req.wr_en    = 1'b1;
        tbl_wr_idx       = k_idx_r;
        tbl_wr_data      = k_ent_r;
        tbl_wr_data.free = 1'b1;
        copy_nxt         = k_ent_r.size;
        state_nxt        = S_DONE;
      end

      S_BUMP: begin
        if (count_r >= CW'(MAX_BLOCKS)) begin
          st_nxt    = ST_TABLE;
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = bump37;
          gap_nxt   = 1'b0;
          end_nxt   = bump37 + HDR37 + {5'b0, req_r};
          state_nxt = S_COVER;
        end
      end

      S_ALN1: begin
        x_nxt     = base37 + bump37 + HDR37;
        state_nxt = S_ALN2;
      end

      S_ALN2: begin
        if (mis) begin
          x_nxt = (x_r & ~mask37) + {5'b0, align_r};
        end
        state_nxt = S_ALN3;
      end

      S_ALN3: begin
        pos_nxt   = x_r - HDR37 - base37;
        state_nxt = S_ALN4;
      end

      S_ALN4: begin
        if (slots_sum > MAXC) begin
          st_nxt    = ST_TABLE;
          state_nxt = S_DONE;
        end else begin
          gap_nxt   = gap;
          end_nxt   = pos_r + HDR37 + {5'b0, req_r};
          state_nxt = S_COVER;
        end
      end

      S_COVER: begin
        if (fits) begin
          state_nxt = gap_r ? S_WR_GAP : S_WR_BLK;
        end else if (need_ok) begin
          pages_nxt = need[15:0];
          state_nxt = gap_r ? S_WR_GAP : S_WR_BLK;
        end else begin
          // Pages taken up to the limit stay held.
          if (pages_r < limit_r) begin
            pages_nxt = limit_r;
          end
          st_nxt    = ST_PAGES;
          state_nxt = S_DONE;
        end
      end

      S_WR_GAP: begin
        tbl_req.wr_en      = 1'b1;
        tbl_wr_data.offset = bump_r;
        tbl_wr_data.size   = 32'(diff - HDR37);
        tbl_wr_data.free   = 1'b1;
        count_nxt          = count_r + CW'(1);
        state_nxt          = S_WR_BLK;
      end

      S_WR_BLK: begin
        tbl_req.wr_en      = 1'b1;
        tbl_wr_data.offset = pos_r[31:0];
        tbl_wr_data.size   = req_r;
        tbl_wr_data.free   = 1'b0;
        count_nxt          = count_r + CW'(1);
        bump_nxt           = end_r[31:0];
        addr_nxt           = base_r + pos_r[31:0] + HDR32;
        state_nxt          = moving_r ? S_MARK_OLD : S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register parts the sequencer from the output side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr_r <= addr_r;
      out_st_r   <= st_r;
      out_copy_r <= copy_r;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.result_address = out_addr_r;
  assign out_chan.status         = out_st_r;
  assign out_chan.copy_bytes     = out_copy_r;

  // Checks on the sequencer and table bookkeeping.
  `FFBHA_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(MAX_BLOCKS), "entry count past table depth")
  `FFBHA_ASSERT_NEXT(a_pages_grow, 1'b1, pages_r >= $past(pages_r), "pages held shrank")
  `FFBHA_ASSERT_SAME(a_wr_in_use, tbl_req.wr_en, {1'b0, tbl_wr_idx} <= (IW + 1)'(count_r), "table write beyond appended entries")
  `FFBHA_ASSERT_SAME(a_copy_move, out_load && copy_r != 32'd0, moving_r && st_r == ST_OK, "copy length without a move")

endmodule
